FILE: src/rbwfc_pkg.sv
// Package with the constants and codes of the ring buffer watermark flow control block.
package rbwfc_pkg;

    localparam int ADDR_BITS = 16;
    localparam int POS_W     = 16;
    localparam int SIZE_W    = ADDR_BITS + 1;
    localparam int LG_W      = 5;
    localparam int AMT_W     = 15;
    localparam int RES_W     = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DRAIN = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SIZE_LOG2    = 3'd0,
        REG_READ_BLOCK   = 3'd1,
        REG_WRITE_BLOCK  = 3'd2,
        REG_READ_MIN     = 3'd3,
        REG_WRITE_MIN    = 3'd4,
        REG_READ_RESUME  = 3'd5,
        REG_WRITE_RESUME = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

endpackage

FILE: src/ring_buffer_watermark_flow_control.sv
// Top level of the ring buffer watermark flow control block.

// Each query transfer names a side (tuser: 0 read space, 1 write data, 2 end of input) and
// carries the producer and consumer positions of a power-of-two ring. One result transfer
// follows each query with the granted byte count and the queried side's stall flag. The
// block holds one query in an input register and one result in an output register, so it
// takes a transfer every cycle unless both are full and the output is stalled. Registers
// are to be set through APB only while no query is in flight (the block does not enforce
// this); writing a nonzero write resume point stalls the write side until fill reaches it.
module ring_buffer_watermark_flow_control (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbwfc_pkg::APB_AW-1:0]  paddr,
    input  logic [rbwfc_pkg::APB_DW-1:0]  pwdata,
    output logic [rbwfc_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // write_position, read_position
    input  logic [1:0]                    s_axis_tuser,  // func

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // grant, zero pad
    output logic [0:0]                    m_axis_tuser   // stalled
);

    localparam int POS_W  = rbwfc_pkg::POS_W;
    localparam int SIZE_W = rbwfc_pkg::SIZE_W;
    localparam int AMT_W  = rbwfc_pkg::AMT_W;
    localparam int RES_W  = rbwfc_pkg::RES_W;
    localparam int LG_W   = rbwfc_pkg::LG_W;

    logic [LG_W-1:0]  r_size_log2;
    logic [AMT_W-1:0] r_read_block;
    logic [AMT_W-1:0] r_write_block;
    logic [AMT_W-1:0] r_read_min;
    logic [AMT_W-1:0] r_write_min;
    logic [RES_W-1:0] r_read_resume;
    logic [RES_W-1:0] r_write_resume;

    logic r_read_stalled;
    logic r_write_stalled;
    logic r_draining;

    logic                  r_in_valid;
    rbwfc_pkg::t_func      r_in_func;
    logic [POS_W-1:0]      r_in_wp;
    logic [POS_W-1:0]      r_in_rp;

    logic                  r_out_valid;
    logic [AMT_W-1:0]      r_out_grant;
    logic                  r_out_stalled;

    logic                  n_read_stalled;
    logic                  n_write_stalled;
    logic                  n_draining;
    logic [AMT_W-1:0]      n_grant;
    logic                  n_stalled;

    logic                  cfg_wr;
    rbwfc_pkg::t_reg_idx   cfg_idx;
    logic                  out_free;
    logic                  stage_move;
    logic                  in_take;

    logic [LG_W-1:0]       lg;
    logic [SIZE_W-1:0]     size;
    logic [POS_W-1:0]      mask;
    logic [POS_W-1:0]      space_raw;
    logic [SIZE_W-1:0]     space;
    logic [SIZE_W-1:0]     resume_ext;
    logic [SIZE_W-1:0]     thresh;
    logic [POS_W-1:0]      fill;
    logic [AMT_W-1:0]      wmin;
    logic [RES_W-1:0]      wres;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = rbwfc_pkg::t_reg_idx'(paddr[rbwfc_pkg::APB_AW-1:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            rbwfc_pkg::REG_SIZE_LOG2:    prdata = rbwfc_pkg::APB_DW'(r_size_log2);
            rbwfc_pkg::REG_READ_BLOCK:   prdata = rbwfc_pkg::APB_DW'(r_read_block);
            rbwfc_pkg::REG_WRITE_BLOCK:  prdata = rbwfc_pkg::APB_DW'(r_write_block);
            rbwfc_pkg::REG_READ_MIN:     prdata = rbwfc_pkg::APB_DW'(r_read_min);
            rbwfc_pkg::REG_WRITE_MIN:    prdata = rbwfc_pkg::APB_DW'(r_write_min);
            rbwfc_pkg::REG_READ_RESUME:  prdata = rbwfc_pkg::APB_DW'(r_read_resume);
            rbwfc_pkg::REG_WRITE_RESUME: prdata = rbwfc_pkg::APB_DW'(r_write_resume);
            default:                     prdata = '0;
        endcase
    end

    assign out_free      = ~r_out_valid | m_axis_tready;
    assign stage_move    = r_in_valid & out_free;
    assign s_axis_tready = ~r_in_valid | out_free;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    always_comb begin
        lg         = (r_size_log2 > LG_W'(rbwfc_pkg::ADDR_BITS)) ?
                     LG_W'(rbwfc_pkg::ADDR_BITS) : r_size_log2;
        size       = SIZE_W'(1) << lg;
        mask       = POS_W'(size - SIZE_W'(1));
        space_raw  = (r_in_rp - r_in_wp) & mask;
        space      = (space_raw == '0) ? size : SIZE_W'(space_raw);
        resume_ext = SIZE_W'(r_read_resume);
        thresh     = (resume_ext < size) ? (size - resume_ext) : '0;
        fill       = (r_in_wp - r_in_rp) & mask;
        wmin       = r_draining ? AMT_W'(1) : r_write_min;
        wres       = r_draining ? '0 : r_write_resume;

        n_read_stalled  = r_read_stalled;
        n_write_stalled = r_write_stalled;
        n_draining      = r_draining;
        n_grant         = '0;
        n_stalled       = 1'b0;

        case (r_in_func)
            rbwfc_pkg::FUNC_READ: begin
                if (r_read_stalled) begin
                    if (space >= thresh) begin
                        n_read_stalled = 1'b0;
                        n_grant        = r_read_block;
                    end
                end else if (space > SIZE_W'(r_read_block)) begin
                    n_grant = r_read_block;
                end else if (space > SIZE_W'(r_read_min)) begin
                    n_grant = space[AMT_W-1:0];
                end else if (r_read_resume != '0) begin
                    n_read_stalled = 1'b1;
                end
                n_stalled = n_read_stalled;
            end
            rbwfc_pkg::FUNC_WRITE: begin
                if (r_write_stalled) begin
                    if (fill >= wres) begin
                        n_write_stalled = 1'b0;
                        n_grant         = r_write_block;
                    end
                end else if (fill >= POS_W'(r_write_block)) begin
                    n_grant = r_write_block;
                end else if (fill >= POS_W'(wmin)) begin
                    n_grant = fill[AMT_W-1:0];
                end else if (wres != '0) begin
                    n_write_stalled = 1'b1;
                end
                n_stalled = n_write_stalled;
            end
            rbwfc_pkg::FUNC_DRAIN: begin
                n_draining      = 1'b1;
                n_write_stalled = 1'b0;
            end
            default: begin
                n_grant   = '0;
                n_stalled = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2     <= LG_W'(16);
            r_read_block    <= AMT_W'(4096);
            r_write_block   <= AMT_W'(4096);
            r_read_min      <= AMT_W'(4096);
            r_write_min     <= AMT_W'(4096);
            r_read_resume   <= '0;
            r_write_resume  <= '0;
            r_read_stalled  <= 1'b0;
            r_write_stalled <= 1'b0;
            r_draining      <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (stage_move) begin
                r_read_stalled  <= n_read_stalled;
                r_write_stalled <= n_write_stalled;
                r_draining      <= n_draining;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    rbwfc_pkg::REG_SIZE_LOG2:   r_size_log2   <= pwdata[LG_W-1:0];
                    rbwfc_pkg::REG_READ_BLOCK:  r_read_block  <= pwdata[AMT_W-1:0];
                    rbwfc_pkg::REG_WRITE_BLOCK: r_write_block <= pwdata[AMT_W-1:0];
                    rbwfc_pkg::REG_READ_MIN:    r_read_min    <= pwdata[AMT_W-1:0];
                    rbwfc_pkg::REG_WRITE_MIN:   r_write_min   <= pwdata[AMT_W-1:0];
                    rbwfc_pkg::REG_READ_RESUME: r_read_resume <= pwdata[RES_W-1:0];
                    rbwfc_pkg::REG_WRITE_RESUME: begin
                        r_write_resume <= pwdata[RES_W-1:0];
                        if (pwdata[RES_W-1:0] != '0) begin
                            r_write_stalled <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (stage_move) begin
                r_in_valid <= 1'b0;
            end
            if (stage_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func <= rbwfc_pkg::t_func'(s_axis_tuser);
            r_in_wp   <= s_axis_tdata[POS_W-1:0];
            r_in_rp   <= s_axis_tdata[2*POS_W-1:POS_W];
        end
        if (stage_move) begin
            r_out_grant   <= n_grant;
            r_out_stalled <= n_stalled;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_grant};
    assign m_axis_tuser  = r_out_stalled;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for the ring buffer watermark flow control block: grant scoreboard and stream drivers.

typedef struct packed {
    logic [rbwfc_pkg::AMT_W-1:0] grant;
    logic                        stalled;
} t_grant_result;

class grant_scoreboard;
    logic [rbwfc_pkg::LG_W-1:0]  size_log2;
    logic [rbwfc_pkg::AMT_W-1:0] read_block;
    logic [rbwfc_pkg::AMT_W-1:0] write_block;
    logic [rbwfc_pkg::AMT_W-1:0] read_min;
    logic [rbwfc_pkg::AMT_W-1:0] write_min;
    logic [rbwfc_pkg::RES_W-1:0] read_resume;
    logic [rbwfc_pkg::RES_W-1:0] write_resume;
    bit                          read_stalled;
    bit                          write_stalled;
    bit                          draining;
    t_grant_result               expected_q[$];
    int unsigned                 mismatches;

    function new();
        size_log2     = 16;
        read_block    = 4096;
        write_block   = 4096;
        read_min      = 4096;
        write_min     = 4096;
        read_resume   = 0;
        write_resume  = 0;
        read_stalled  = 1'b0;
        write_stalled = 1'b0;
        draining      = 1'b0;
        mismatches    = 0;
    endfunction

    function int unsigned ring_size();
        int unsigned lg;
        lg = (size_log2 > rbwfc_pkg::ADDR_BITS) ? rbwfc_pkg::ADDR_BITS : size_log2;
        return 32'd1 << lg;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void set_reg(rbwfc_pkg::t_reg_idx idx, logic [31:0] value);
        case (idx)
            rbwfc_pkg::REG_SIZE_LOG2:    size_log2 = value[rbwfc_pkg::LG_W-1:0];
            rbwfc_pkg::REG_READ_BLOCK:   read_block = value[rbwfc_pkg::AMT_W-1:0];
            rbwfc_pkg::REG_WRITE_BLOCK:  write_block = value[rbwfc_pkg::AMT_W-1:0];
            rbwfc_pkg::REG_READ_MIN:     read_min = value[rbwfc_pkg::AMT_W-1:0];
            rbwfc_pkg::REG_WRITE_MIN:    write_min = value[rbwfc_pkg::AMT_W-1:0];
            rbwfc_pkg::REG_READ_RESUME:  read_resume = value[rbwfc_pkg::RES_W-1:0];
            rbwfc_pkg::REG_WRITE_RESUME: begin
                write_resume = value[rbwfc_pkg::RES_W-1:0];
                if (write_resume != 0) write_stalled = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function logic [rbwfc_pkg::AMT_W-1:0] predict_read(logic [rbwfc_pkg::POS_W-1:0] wp,
                                                       logic [rbwfc_pkg::POS_W-1:0] rp);
        int unsigned size;
        int unsigned space;
        int unsigned thresh;
        size  = ring_size();
        space = (32'(rp) - 32'(wp)) & (size - 1);
        if (space == 0) space = size;
        if (read_stalled) begin
            thresh = (read_resume < size) ? size - read_resume : 0;
            if (space < thresh) return '0;
            read_stalled = 1'b0;
            return read_block;
        end
        if (space > read_block) return read_block;
        if (space > read_min) return rbwfc_pkg::AMT_W'(space);
        if (read_resume != 0) read_stalled = 1'b1;
        return '0;
    endfunction

    function logic [rbwfc_pkg::AMT_W-1:0] predict_write(logic [rbwfc_pkg::POS_W-1:0] wp,
                                                        logic [rbwfc_pkg::POS_W-1:0] rp);
        int unsigned fill;
        int unsigned wmin;
        int unsigned wres;
        fill = (32'(wp) - 32'(rp)) & (ring_size() - 1);
        wmin = draining ? 1 : write_min;
        wres = draining ? 0 : write_resume;
        if (write_stalled) begin
            if (fill < wres) return '0;
            write_stalled = 1'b0;
            return write_block;
        end
        if (fill >= write_block) return write_block;
        if (fill >= wmin) return rbwfc_pkg::AMT_W'(fill);
        if (wres != 0) write_stalled = 1'b1;
        return '0;
    endfunction

    function void note_query(rbwfc_pkg::t_func f, logic [rbwfc_pkg::POS_W-1:0] wp,
                             logic [rbwfc_pkg::POS_W-1:0] rp);
        t_grant_result r;
        r.grant   = '0;
        r.stalled = 1'b0;
        case (f)
            rbwfc_pkg::FUNC_READ: begin
                r.grant   = predict_read(wp, rp);
                r.stalled = read_stalled;
            end
            rbwfc_pkg::FUNC_WRITE: begin
                r.grant   = predict_write(wp, rp);
                r.stalled = write_stalled;
            end
            rbwfc_pkg::FUNC_DRAIN: begin
                draining      = 1'b1;
                write_stalled = 1'b0;
            end
            default: ;
        endcase
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [rbwfc_pkg::AMT_W-1:0] grant, logic stalled);
        t_grant_result exp_r;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: grant %0d stalled %0d", grant, stalled);
            return;
        end
        exp_r = expected_q.pop_front();
        if (exp_r.grant !== grant || exp_r.stalled !== stalled) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected grant %0d stalled %0d, got grant %0d stalled %0d",
                         exp_r.grant, exp_r.stalled, grant, stalled);
        end
    endfunction
endclass

module tb;
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rbwfc_pkg::APB_AW-1:0]  paddr = '0;
    logic [rbwfc_pkg::APB_DW-1:0]  pwdata = '0;
    logic [rbwfc_pkg::APB_DW-1:0]  prdata;
    logic                          pready;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [31:0]                   s_axis_tdata = '0;
    logic [1:0]                    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;
    logic [0:0]                    m_axis_tuser;

    grant_scoreboard     sb = new();
    bit                  calm = 1'b0;
    bit                  hold_req = 1'b0;
    int unsigned         results_taken = 0;

    ring_buffer_watermark_flow_control u_top (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #1000000;
        $display("tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_query(rbwfc_pkg::t_func'(s_axis_tuser), s_axis_tdata[15:0],
                              s_axis_tdata[31:16]);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata[rbwfc_pkg::AMT_W-1:0], m_axis_tuser[0]);
                results_taken++;
            end
        end
    end

    initial begin
        int unsigned rx_seen;
        int unsigned rx_wait;
        int unsigned hold_left;
        bit          hold_done;
        rx_seen   = 0;
        rx_wait   = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (rx_seen != results_taken) begin
                rx_seen = results_taken;
                rx_wait = calm ? 0 : $urandom_range(0, 17);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic int unsigned pick_gap();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic int unsigned pick_amount(int unsigned size, int unsigned m0,
                                                int unsigned m1, int unsigned m2);
        int unsigned base;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, size - 1);
            3:       return 0;
            4:       return size - 1;
            5, 6:    base = m0;
            7, 8:    base = m1;
            default: base = m2;
        endcase
        return (base + $urandom_range(0, 2) - 1) & (size - 1);
    endfunction

    task automatic apb_write(input rbwfc_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int unsigned lg, input int unsigned rb, input int unsigned wb,
                             input int unsigned rmin, input int unsigned wmin,
                             input int unsigned rres, input int unsigned wres);
        apb_write(rbwfc_pkg::REG_SIZE_LOG2, lg);
        apb_write(rbwfc_pkg::REG_READ_BLOCK, rb);
        apb_write(rbwfc_pkg::REG_WRITE_BLOCK, wb);
        apb_write(rbwfc_pkg::REG_READ_MIN, rmin);
        apb_write(rbwfc_pkg::REG_WRITE_MIN, wmin);
        apb_write(rbwfc_pkg::REG_READ_RESUME, rres);
        apb_write(rbwfc_pkg::REG_WRITE_RESUME, wres);
    endtask

    task automatic random_setup();
        int unsigned lg;
        int unsigned size;
        int unsigned bmax;
        lg   = $urandom_range(4, 16);
        size = 32'd1 << lg;
        bmax = size / 2 - 1;
        if (bmax > 32767) bmax = 32767;
        configure(lg, $urandom_range(1, bmax), $urandom_range(1, bmax),
                  $urandom_range(1, bmax), $urandom_range(1, bmax),
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, size - 1),
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, size - 1));
    endtask

    task automatic send_query(input rbwfc_pkg::t_func f, input logic [15:0] wp,
                              input logic [15:0] rp, input int unsigned gap);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {rp, wp};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic random_query(input bit with_drain);
        int unsigned       r;
        int unsigned       size;
        int unsigned       amt;
        logic [15:0]       wp;
        logic [15:0]       rp;
        rbwfc_pkg::t_func  f;
        size = sb.ring_size();
        r    = $urandom_range(0, 99);
        rp   = 16'($urandom);
        wp   = 16'($urandom);
        if (r < 46) begin
            f   = rbwfc_pkg::FUNC_READ;
            amt = pick_amount(size, sb.read_block, sb.read_min, size - sb.read_resume);
            wp  = rp - 16'(amt);
        end else if (r < 92) begin
            f   = rbwfc_pkg::FUNC_WRITE;
            amt = pick_amount(size, sb.write_block, sb.write_min, sb.write_resume);
            wp  = rp + 16'(amt);
        end else if (with_drain && r < 94) begin
            f = rbwfc_pkg::FUNC_DRAIN;
        end else begin
            f = rbwfc_pkg::FUNC_NONE;
        end
        send_query(f, wp, rp, pick_gap());
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_query(rbwfc_pkg::FUNC_READ, 16'h0000, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'h0000, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'hFFFF, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'hFFFF, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'd3000, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'h0000, 16'hFFFF, pick_gap());
        send_query(rbwfc_pkg::FUNC_NONE, 16'hFFFF, 16'hFFFF, pick_gap());
        wait_results();

        configure(4, 7, 7, 2, 3, 10, 12);
        send_query(rbwfc_pkg::FUNC_WRITE, 16'h0005, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'hFF0C, 16'hFF00, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'h000F, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'h0004, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'h0002, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_WRITE, 16'h000B, 16'h0000, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'h1234, 16'h5674, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'h0000, 16'h0005, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'h0000, 16'h0002, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'h0000, 16'h0005, pick_gap());
        send_query(rbwfc_pkg::FUNC_READ, 16'h0000, 16'h0006, pick_gap());
        send_query(rbwfc_pkg::FUNC_NONE, 16'h0000, 16'h0000, pick_gap());
        wait_results();

        // End of input lasts until reset, so it comes only after the phases that
        // exercise the normal write thresholds.
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       configure(16, 32767, 32767, 32767, 32767, 65535, 65535);
                1:       configure(4, 1, 1, 1, 1, 0, 0);
                2:       configure(31, 4096, 2048, 100, 3000, 60000, 1);
                3:       configure(8, 100, 60, 20, 30, 200, 150);
                7:       configure(4, 7, 7, 3, 5, 16, 8);
                default: random_setup();
            endcase
            calm = (phase % 3 == 1);
            if (phase == 3) begin
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (24) random_query(1'b0);
                calm     = 1'b0;
            end
            if (phase == 6)
                send_query(rbwfc_pkg::FUNC_DRAIN, 16'hFFFF, 16'h0000, pick_gap());
            repeat (40) random_query(phase >= 6);
            wait_results();
        end

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
